// ===== rtl/olrb_pkg.sv =====
package olrb_pkg;

  // Store geometry
  localparam int BUF_DEPTH = 4096;
  localparam int PTR_W     = $clog2(BUF_DEPTH);
  localparam int STORED_W  = $clog2(BUF_DEPTH + 1);

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 16;
  localparam int CNT_W   = 17;
  // Wide enough for write pointer plus depth without overflow
  localparam int POS_W   = (PTR_W + 2 > CNT_W + 1) ? PTR_W + 2 : CNT_W + 1;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_SUPPRESS = '0;

  // Item opcodes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ADDR = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic append;    // store an appended byte (datapath applies suppress)
    logic capture;   // latch window count, index and valid flag
    logic mem_read;  // form the store address and read it
    logic out_load;  // move the finished read into the output registers
  } dp_cmd_t;

endpackage

// ===== rtl/olrb_ctrl.sv =====
module olrb_ctrl
  import olrb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_op,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_APPEND)) begin
          cmd.append = 1'b1;
        end
        if (accept && (in_op == OP_READ)) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.mem_read = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_only_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (state_r == ST_FIN))
    else $error("output load outside finish state");

  a_read_reaches_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> ##2 (state_r == ST_FIN))
    else $error("read did not reach finish state");

  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && !out_free |=> (state_r == ST_FIN) && out_valid_r)
    else $error("finished read lost while output blocked");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.append, cmd.capture, cmd.mem_read, cmd.out_load}))
    else $error("conflicting datapath commands");

endmodule

// ===== rtl/olrb_datapath.sv =====
module olrb_datapath
  import olrb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic [BYTE_W-1:0]     in_log_byte,
  input  logic [LEN_W-1:0]      in_window_len,
  input  logic [LEN_W-1:0]      in_window_index,
  output logic [BYTE_W-1:0]     out_read_byte,
  output logic [CNT_W-1:0]      out_window_count,
  output logic                  out_index_valid,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [BYTE_W-1:0] mem [BUF_DEPTH];

  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic              suppress_r, suppress_nxt;
  logic              store_en;

  logic [CNT_W-1:0]  count_r;
  logic [LEN_W-1:0]  widx_r;
  logic              idx_valid_r;
  logic [BYTE_W-1:0] rd_data_r;

  logic [CNT_W-1:0]  stored;
  logic [CNT_W-1:0]  count_c;
  logic [POS_W-1:0]  back;
  logic [POS_W-1:0]  pos_sum;
  logic [POS_W-1:0]  pos_fix;
  logic [PTR_W-1:0]  rd_addr;
  logic              reg_hit;

  // Configuration: one register, written in the access phase
  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_SUPPRESS);
  assign prdata  = reg_hit ? {{(CFG_DATA_W-1){1'b0}}, suppress_r} : '0;

  always_comb begin
    suppress_nxt = suppress_r;
    if (psel && penable && pwrite && reg_hit) begin
      suppress_nxt = pwdata[0];
    end
  end

  // Write pointer and wrap flag
  assign store_en = cmd.append && !suppress_r;

  always_comb begin
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    if (store_en) begin
      if (wp_r == PTR_W'(BUF_DEPTH - 1)) begin
        wp_nxt      = '0;
        wrapped_nxt = 1'b1;
      end else begin
        wp_nxt = wp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      wrapped_r  <= 1'b0;
      suppress_r <= 1'b0;
    end else begin
      wp_r       <= wp_nxt;
      wrapped_r  <= wrapped_nxt;
      suppress_r <= suppress_nxt;
    end
  end

  // Window size and index check at acceptance
  assign stored  = wrapped_r ? CNT_W'(BUF_DEPTH) : CNT_W'(wp_r);
  assign count_c = (CNT_W'(in_window_len) < stored) ? CNT_W'(in_window_len) : stored;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      count_r     <= count_c;
      widx_r      <= in_window_index;
      idx_valid_r <= CNT_W'(in_window_index) < count_c;
    end
  end

  // Store address: oldest window byte sits count places behind the pointer
  assign back    = POS_W'(count_r) - POS_W'(widx_r);
  assign pos_sum = POS_W'(wp_r) + POS_W'(BUF_DEPTH) - back;
  assign pos_fix = (pos_sum >= POS_W'(BUF_DEPTH)) ? pos_sum - POS_W'(BUF_DEPTH) : pos_sum;
  assign rd_addr = pos_fix[PTR_W-1:0];

  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[wp_r] <= in_log_byte;
    end
    if (cmd.mem_read) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Output registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_read_byte    <= idx_valid_r ? rd_data_r : '0;
      out_window_count <= count_r;
      out_index_valid  <= idx_valid_r;
    end
  end

  a_wrapped_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    wrapped_r |=> wrapped_r)
    else $error("wrap flag cleared");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    store_en |=> (wp_r == PTR_W'(0)) || (wp_r == $past(wp_r) + 1'b1))
    else $error("write pointer skipped");

endmodule

// ===== rtl/overwrite_log_ring_buffer_core.sv =====
// Overwrite-oldest byte log ring.
//
// Input channel (in_*): one beat carries an op, a byte and a window request.
//   op append stores in_log_byte at the write pointer, overwriting the oldest
//   byte once the 4096-byte store is full; it gives no result beat, and is
//   dropped when the suppress register is set.
//   op read asks for the newest min(stored, in_window_len) bytes, oldest first,
//   and returns one result beat: the window count, the byte at in_window_index
//   and an index-valid flag (byte reads as zero when the index is outside).
// Output channel (out_*): valid/stall; a result holds in the output register
//   until taken, and appends keep flowing meanwhile.
// Rate: appends sustain one beat a cycle while no read is in progress.
//   A read steps through: capture the window, address the store RAM and
//   read its registered port, load the output register. The input stalls
//   until that load, so no new beat is taken while a read is in flight.
// Stall: a read that finishes while the previous result is still stalled
//   waits in its final step, and the input stays stalled until it moves on.
// Reset: synchronous, active low. Write pointer, wrap flag and suppress clear;
//   the store is not cleared, as only written entries ever reach the output.
// Configuration: APB-style, register 0 (byte address 0) is suppress in bit 0.
module overwrite_log_ring_buffer_core
  import olrb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [BYTE_W-1:0]     in_log_byte,
  input  logic [LEN_W-1:0]      in_window_len,
  input  logic [LEN_W-1:0]      in_window_index,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_read_byte,
  output logic [CNT_W-1:0]      out_window_count,
  output logic                  out_index_valid,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  dp_cmd_t cmd;

  // Sequencer: accepts beats, steps reads through the RAM, owns out_valid
  olrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Store, pointers, window arithmetic, output and config registers
  olrb_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_log_byte      (in_log_byte),
    .in_window_len    (in_window_len),
    .in_window_index  (in_window_index),
    .out_read_byte    (out_read_byte),
    .out_window_count (out_window_count),
    .out_index_valid  (out_index_valid),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import olrb_pkg::*;

  // Cycles with no beat on either channel before the run is abandoned. The
  // longest legitimate quiet stretch is the receiver's long hold-off.
  localparam int unsigned QUIET_LIMIT = 5000;
  // Longest hold-off of the receiver while the sender keeps offering beats
  localparam int unsigned LONG_HOLD   = 300;
  // Cycles to let an in-flight append or read settle before a register write
  localparam int unsigned SETTLE      = 8;

  // Byte addresses on the configuration port
  localparam logic [CFG_ADDR_W-1:0] ADDR_SUPPRESS = {REG_SUPPRESS, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = {~REG_SUPPRESS, 2'b00};

  typedef struct {
    logic [BYTE_W-1:0] read_byte;
    logic [CNT_W-1:0]  window_count;
    logic              index_valid;
  } window_read_t;

  // Shadow copy of the log ring: the store, the write pointer, the wrap flag
  // and the suppress register, plus the window reads still owed by the block.
  class log_ring_shadow;
    logic [BYTE_W-1:0] log_mem [BUF_DEPTH];
    logic [PTR_W-1:0]  wr_ptr;
    bit                wrapped;
    bit                suppress;
    window_read_t      owed_reads[$];
    int unsigned       errors;

    function new();
      wr_ptr   = '0;
      wrapped  = 1'b0;
      suppress = 1'b0;
      errors   = 0;
    endfunction

    function int unsigned stored_count();
      return wrapped ? BUF_DEPTH : int'(wr_ptr);
    endfunction

    function int unsigned pending();
      return owed_reads.size();
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_SUPPRESS) suppress = value[0];
    endfunction

    function void note_beat(logic op, logic [BYTE_W-1:0] b, logic [LEN_W-1:0] len,
                            logic [LEN_W-1:0] idx);
      window_read_t r;
      int unsigned  count;
      int unsigned  pos;
      if (op == OP_APPEND) begin
        if (!suppress) begin
          log_mem[wr_ptr] = b;
          wr_ptr = wr_ptr + 1'b1;
          if (wr_ptr == '0) wrapped = 1'b1;
        end
      end else begin
        count = (32'(len) < stored_count()) ? 32'(len) : stored_count();
        r.window_count = count[CNT_W-1:0];
        r.index_valid  = (32'(idx) < count);
        r.read_byte    = '0;
        if (r.index_valid) begin
          // oldest byte of the window lies count places behind the pointer
          pos = (32'(wr_ptr) + BUF_DEPTH - count + 32'(idx)) % BUF_DEPTH;
          r.read_byte = log_mem[PTR_W'(pos)];
        end
        owed_reads.push_back(r);
      end
    endfunction

    function void check_read(logic [BYTE_W-1:0] rb, logic [CNT_W-1:0] cnt, logic iv);
      window_read_t e;
      if (owed_reads.size() == 0) begin
        errors++;
        $error("result beat with no read outstanding");
        return;
      end
      e = owed_reads.pop_front();
      if (rb !== e.read_byte) begin
        errors++;
        $error("read_byte: expected %0h, got %0h", e.read_byte, rb);
      end
      if (cnt !== e.window_count) begin
        errors++;
        $error("window_count: expected %0d, got %0d", e.window_count, cnt);
      end
      if (iv !== e.index_valid) begin
        errors++;
        $error("index_valid: expected %0b, got %0b", e.index_valid, iv);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_op;
  logic [BYTE_W-1:0]     in_log_byte;
  logic [LEN_W-1:0]      in_window_len;
  logic [LEN_W-1:0]      in_window_index;
  logic                  out_valid;
  logic                  out_stall;
  logic [BYTE_W-1:0]     out_read_byte;
  logic [CNT_W-1:0]      out_window_count;
  logic                  out_index_valid;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Idling controls for the sender and the receiver
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          long_hold_req;
  int unsigned quiet_cycles = 0;

  log_ring_shadow shadow = new();

  overwrite_log_ring_buffer_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_log_byte      (in_log_byte),
    .in_window_len    (in_window_len),
    .in_window_index  (in_window_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_byte    (out_read_byte),
    .out_window_count (out_window_count),
    .out_index_valid  (out_index_valid),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #4 clk = ~clk;

  // Drop the input valid and hold it low for a burst of cycles. Always
  // advances at least one edge, so a following raise lands in a later step.
  task automatic idle_sender(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Offer one beat and hold it until the block takes it. Valid is left high
  // so that back-to-back beats need no second assignment in one step.
  task automatic send_beat(input logic op, input logic [BYTE_W-1:0] b,
                           input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] idx);
    in_valid        <= 1'b1;
    in_op           <= op;
    in_log_byte     <= b;
    in_window_len   <= len;
    in_window_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.note_beat(op, b, len, idx);
    if (tx_idle_en && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 7));
  endtask

  // Build a beat with random content. Window lengths lean towards the
  // stored count and indexes run up to the window edge and sometimes past
  // it, where the address arithmetic wraps and the valid flag flips.
  task automatic send_random(input int unsigned read_pct);
    logic              op;
    logic [BYTE_W-1:0] b;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  idx;
    int unsigned       stored;
    int unsigned       span;
    stored = shadow.stored_count();
    op     = ($urandom_range(0, 99) < read_pct) ? OP_READ : OP_APPEND;
    b      = BYTE_W'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       len = '0;
      1:       len = LEN_W'($urandom_range(0, 65535));
      2:       len = '1;
      3, 4:    len = LEN_W'(stored + $urandom_range(0, 4) - 2);
      default: len = LEN_W'($urandom_range(1, 64));
    endcase
    span = (32'(len) < stored) ? 32'(len) : stored;
    if ($urandom_range(0, 4) == 0) idx = LEN_W'($urandom_range(0, 65535));
    else                           idx = LEN_W'($urandom_range(0, span));
    send_beat(op, b, len, idx);
  endtask

  // Stop offering beats, wait for every owed read, then let any append
  // still in the pipe settle.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // edge where the access phase meets pready.
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow.write_reg(addr[CFG_ADDR_W-1:2], data);
    @(posedge clk);
  endtask

  // Receiver: one decision per edge. A long hold-off, once asked for, is
  // counted down here so the sender can keep pushing meanwhile.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD - 1;
        out_stall     <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check every result beat taken at this edge against the oldest owed read
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      shadow.check_read(out_read_byte, out_window_count, out_index_valid);
  end

  // Watchdog: abandon the run after too long without any beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = OP_APPEND;
    in_log_byte     = '0;
    in_window_len   = '0;
    in_window_index = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    tx_idle_en      = 1'b0;
    rx_idle_en      = 1'b0;
    long_hold_req   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_write(ADDR_SUPPRESS, '0);

    // Directed: reads of an empty ring, zero window, a few extreme bytes,
    // windows longer than the store, indexes on and past the window edge.
    send_beat(OP_READ,   8'h00, 16'h0000, 16'h0000);
    send_beat(OP_READ,   8'hFF, 16'hFFFF, 16'h0000);
    send_beat(OP_APPEND, 8'h00, 16'hFFFF, 16'hFFFF);
    send_beat(OP_APPEND, 8'hFF, 16'h0000, 16'h0000);
    send_beat(OP_APPEND, 8'hA5, 16'h5A5A, 16'hA5A5);
    send_beat(OP_APPEND, 8'h5A, 16'hA5A5, 16'h5A5A);
    send_beat(OP_READ,   8'h00, 16'h0000, 16'h0000);
    send_beat(OP_READ,   8'h00, 16'hFFFF, 16'h0000);
    send_beat(OP_READ,   8'h00, 16'hFFFF, 16'h0003);
    send_beat(OP_READ,   8'h00, 16'hFFFF, 16'h0004);
    send_beat(OP_READ,   8'h00, 16'hFFFF, 16'hFFFF);
    send_beat(OP_READ,   8'h00, 16'h0002, 16'h0000);
    send_beat(OP_READ,   8'h00, 16'h0002, 16'h0001);
    send_beat(OP_READ,   8'h00, 16'h0002, 16'h0002);
    send_beat(OP_READ,   8'h00, 16'h0004, 16'h0003);

    // Suppressed appends vanish; reads are still served
    quiesce();
    cfg_write(ADDR_SUPPRESS, 32'h0000_0001);
    send_beat(OP_APPEND, 8'h77, 16'h0000, 16'h0000);
    send_beat(OP_APPEND, 8'h88, 16'hFFFF, 16'hFFFF);
    send_beat(OP_READ,   8'h00, 16'hFFFF, 16'h0003);
    send_beat(OP_READ,   8'h00, 16'h0001, 16'h0000);

    // Only bit 0 counts, and the unmapped address must not touch suppress
    quiesce();
    cfg_write(ADDR_SUPPRESS, 32'hFFFF_FFFE);
    cfg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    send_beat(OP_APPEND, 8'h3C, 16'h0000, 16'h0000);
    send_beat(OP_READ,   8'h00, 16'hFFFF, 16'h0004);
    send_beat(OP_READ,   8'h00, 16'h0001, 16'h0000);

    // Random traffic with idling on both sides
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (200) send_random(40);
    // Pause the sender until every owed read has come back
    quiesce();
    repeat (200) send_random(40);

    quiesce();
    cfg_write(ADDR_SUPPRESS, 32'h8000_0001);
    repeat (150) send_random(50);

    // Long receiver hold-off while the sender keeps offering beats, so
    // reads back up and the input stalls
    quiesce();
    cfg_write(ADDR_SUPPRESS, '0);
    tx_idle_en    = 1'b0;
    long_hold_req = 1'b1;
    repeat (120) send_random(50);

    // Grow the ring with mostly appends, then probe windows at and beyond
    // the store size
    tx_idle_en = 1'b1;
    repeat (200) send_random(8);
    send_beat(OP_READ, 8'h00, 16'h0FFF, 16'h0000);
    send_beat(OP_READ, 8'h00, 16'h0FFF, 16'h0FFE);
    send_beat(OP_READ, 8'h00, 16'h1000, 16'h0FFF);
    send_beat(OP_READ, 8'h00, 16'h1000, 16'h1000);
    send_beat(OP_READ, 8'h00, 16'h1001, 16'h0000);
    send_beat(OP_READ, 8'h00, 16'hFFFF, 16'h0FFF);
    send_beat(OP_READ, 8'h00, 16'hFFFF, 16'hFFFF);

    repeat (500) send_random(40);

    // Closing stretch with no idling at all
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (300) send_random(40);

    quiesce();
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== overwrite_log_ring_buffer_core.f =====
rtl/olrb_pkg.sv
rtl/olrb_ctrl.sv
rtl/olrb_datapath.sv
rtl/overwrite_log_ring_buffer_core.sv
sim/tb.sv
